@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the rtl, empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

`define ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(name, clk, rst_n, prop)

`define ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

@@ hw/rtl/wavhp_pkg.sv @@
// types and constants of the wav header parser
package wavhp_pkg;

  localparam int unsigned PosWidthDefault = 32;

  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6d66;
  localparam logic [31:0] TagData = 32'h6174_6164;
  localparam logic [31:0] TagList = 32'h5453_494c;

  localparam logic [31:0] FmtBodyBytes = 32'd16;
  localparam logic [15:0] FmtPcm       = 16'd1;
  localparam logic [15:0] Bits8        = 16'd8;
  localparam logic [15:0] Bits16       = 16'd16;
  localparam logic [15:0] ChanMono     = 16'd1;
  localparam logic [15:0] ChanStereo   = 16'd2;

  localparam int unsigned OutDataWidth = 184;

  typedef enum logic [3:0] {
    PH_RIFF,
    PH_RSIZE,
    PH_WAVE,
    PH_ID,
    PH_FMTSZ,
    PH_DATASZ,
    PH_LISTSZ,
    PH_OTHERSZ,
    PH_F0,
    PH_F1,
    PH_F2,
    PH_F3,
    PH_SKIP,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_RIFF,
    ST_BAD_WAVE,
    ST_MISSING,
    ST_NOT_PCM,
    ST_BAD_BITS,
    ST_BAD_CHAN
  } status_t;

  typedef struct packed {
    logic riff;
    logic wave;
    logic fmt;
    logic data;
    logic lst;
  } tag_flags_t;

  typedef struct packed {
    status_t     status;
    logic [1:0]  sample_format;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_alignment;
    logic [15:0] sample_bits;
    logic [31:0] data_offset;
    logic [31:0] data_length;
  } result_t;

endpackage

@@ hw/rtl/wavhp_parser.sv @@
// byte-wise riff/wave chunk walker with field capture and result build
module wavhp_parser import wavhp_pkg::*; #(
  parameter int unsigned POS_WIDTH = PosWidthDefault
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_acc,
  input  logic [7:0] in_byte,
  input  logic       in_first,
  input  logic       in_last,
  output logic       res_vld,
  output result_t    res,
  output logic       prs_done
);

  localparam int unsigned OffBits = (POS_WIDTH < 32) ? POS_WIDTH : 32;

  phase_t                 phase_r, phase_nxt;
  logic [1:0]             cnt_r, cnt_nxt;
  logic [31:0]            asm_r, asm_nxt;
  logic [POS_WIDTH-1:0]   pos_r, pos_nxt;
  logic [31:0]            skip_r, skip_nxt;
  tag_flags_t             flags_r, flags_nxt;
  logic [15:0]            fcode_r, fcode_nxt;
  logic [15:0]            ch_r, ch_nxt;
  logic [31:0]            rate_r, rate_nxt;
  logic [31:0]            brate_r, brate_nxt;
  logic [15:0]            align_r, align_nxt;
  logic [15:0]            bits_r, bits_nxt;
  logic [31:0]            off_r, off_nxt;
  logic [31:0]            len_r, len_nxt;
  logic                   emit;

  always_comb begin
    logic [31:0]          word;
    logic [31:0]          skip_dec;
    logic [POS_WIDTH-1:0] pos_inc;
    logic                 all_seen;

    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    asm_nxt   = asm_r;
    pos_nxt   = pos_r;
    skip_nxt  = skip_r;
    flags_nxt = flags_r;
    fcode_nxt = fcode_r;
    ch_nxt    = ch_r;
    rate_nxt  = rate_r;
    brate_nxt = brate_r;
    align_nxt = align_r;
    bits_nxt  = bits_r;
    off_nxt   = off_r;
    len_nxt   = len_r;
    all_seen  = 1'b0;
    emit      = 1'b0;

    // a new file wipes everything, then its byte is parsed as byte zero
    if (in_acc && in_first) begin
      phase_nxt = PH_RIFF;
      cnt_nxt   = '0;
      asm_nxt   = '0;
      pos_nxt   = '0;
      skip_nxt  = '0;
      flags_nxt = '0;
      fcode_nxt = '0;
      ch_nxt    = '0;
      rate_nxt  = '0;
      brate_nxt = '0;
      align_nxt = '0;
      bits_nxt  = '0;
      off_nxt   = '0;
      len_nxt   = '0;
    end

    word     = {in_byte, asm_nxt[31:8]};
    skip_dec = skip_nxt - 32'd1;
    pos_inc  = pos_nxt + POS_WIDTH'(1);

    if (in_acc && (phase_nxt != PH_DONE)) begin
      if (phase_nxt == PH_SKIP) begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          phase_nxt = PH_ID;
        end
      end else begin
        asm_nxt = word;
        if (cnt_nxt == 2'd3) begin
          cnt_nxt = '0;
          case (phase_nxt)
            PH_RIFF: begin
              if (word == TagRiff) flags_nxt.riff = 1'b1;
              phase_nxt = PH_RSIZE;
            end
            PH_RSIZE: begin
              phase_nxt = PH_WAVE;
            end
            PH_WAVE: begin
              if (word == TagWave) flags_nxt.wave = 1'b1;
              phase_nxt = PH_ID;
            end
            PH_ID: begin
              if (word == TagFmt)       phase_nxt = PH_FMTSZ;
              else if (word == TagData) phase_nxt = PH_DATASZ;
              else if (word == TagList) phase_nxt = PH_LISTSZ;
              else                      phase_nxt = PH_OTHERSZ;
            end
            PH_FMTSZ: begin
              // extra fmt bytes are skipped after the fixed body
              skip_nxt  = (word > FmtBodyBytes) ? (word - FmtBodyBytes) : '0;
              phase_nxt = PH_F0;
            end
            PH_DATASZ: begin
              len_nxt        = word;
              off_nxt        = 32'(pos_inc[OffBits-1:0]);
              flags_nxt.data = 1'b1;
              skip_nxt       = word;
              phase_nxt      = (word != '0) ? PH_SKIP : PH_ID;
              all_seen       = flags_nxt.fmt & flags_nxt.data & flags_nxt.lst;
            end
            PH_LISTSZ: begin
              flags_nxt.lst = 1'b1;
              skip_nxt      = word;
              phase_nxt     = (word != '0) ? PH_SKIP : PH_ID;
              all_seen      = flags_nxt.fmt & flags_nxt.data & flags_nxt.lst;
            end
            PH_OTHERSZ: begin
              skip_nxt  = word;
              phase_nxt = (word != '0) ? PH_SKIP : PH_ID;
            end
            PH_F0: begin
              fcode_nxt = word[15:0];
              ch_nxt    = word[31:16];
              phase_nxt = PH_F1;
            end
            PH_F1: begin
              rate_nxt  = word;
              phase_nxt = PH_F2;
            end
            PH_F2: begin
              brate_nxt = word;
              phase_nxt = PH_F3;
            end
            PH_F3: begin
              align_nxt     = word[15:0];
              bits_nxt      = word[31:16];
              flags_nxt.fmt = 1'b1;
              phase_nxt     = (skip_nxt != '0) ? PH_SKIP : PH_ID;
              all_seen      = flags_nxt.fmt & flags_nxt.data & flags_nxt.lst;
            end
            default: begin
            end
          endcase
        end else begin
          cnt_nxt = cnt_nxt + 2'd1;
        end
      end
      pos_nxt = pos_inc;
      emit    = all_seen | in_last;
      if (emit) begin
        phase_nxt = PH_DONE;
      end
    end
  end

  // result fields, built from the state as it stands after this byte
  always_comb begin
    res                 = '0;
    res.channel_count   = ch_nxt;
    res.sample_rate     = rate_nxt;
    res.byte_rate       = brate_nxt;
    res.block_alignment = align_nxt;
    res.sample_bits     = bits_nxt;
    res.data_offset     = off_nxt;
    res.data_length     = len_nxt;
    if (!flags_nxt.riff) begin
      res.status = ST_BAD_RIFF;
    end else if (!flags_nxt.wave) begin
      res.status = ST_BAD_WAVE;
    end else if (!(flags_nxt.fmt && flags_nxt.data)) begin
      res.status = ST_MISSING;
    end else if (fcode_nxt != FmtPcm) begin
      res.status = ST_NOT_PCM;
    end else if (!(bits_nxt inside {Bits8, Bits16})) begin
      res.status = ST_BAD_BITS;
    end else if (!(ch_nxt inside {ChanMono, ChanStereo})) begin
      res.status = ST_BAD_CHAN;
    end else begin
      res.status        = ST_OK;
      res.sample_format = {bits_nxt == Bits16, ch_nxt == ChanStereo};
    end
  end

  assign res_vld  = emit;
  assign prs_done = (phase_r == PH_DONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RIFF;
      cnt_r   <= '0;
      asm_r   <= '0;
      pos_r   <= '0;
      skip_r  <= '0;
      flags_r <= '0;
      fcode_r <= '0;
      ch_r    <= '0;
      rate_r  <= '0;
      brate_r <= '0;
      align_r <= '0;
      bits_r  <= '0;
      off_r   <= '0;
      len_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      asm_r   <= asm_nxt;
      pos_r   <= pos_nxt;
      skip_r  <= skip_nxt;
      flags_r <= flags_nxt;
      fcode_r <= fcode_nxt;
      ch_r    <= ch_nxt;
      rate_r  <= rate_nxt;
      brate_r <= brate_nxt;
      align_r <= align_nxt;
      bits_r  <= bits_nxt;
      off_r   <= off_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

@@ hw/rtl/wavhp_out_buf.sv @@
// two-entry result buffer: output register plus skid entry
module wavhp_out_buf import wavhp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_vld,
  input  result_t res,
  output logic    res_rdy,
  output logic    out_vld,
  input  logic    out_rdy,
  output result_t out_res
);

  logic    main_vld_r, main_vld_nxt;
  logic    skid_vld_r, skid_vld_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (skid_vld_r) begin
      if (out_rdy) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (!main_vld_r || out_rdy) begin
      main_vld_nxt = res_vld;
      if (res_vld) main_nxt = res;
    end else if (res_vld) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign res_rdy = !skid_vld_r;
  assign out_vld = main_vld_r;
  assign out_res = main_r;

endmodule

@@ hw/rtl/wav_header_parser_top.sv @@
// wav header parser: riff/wave byte stream in, one header summary word out
//
// usage
//   in_*  : one file byte per word; in_tuser marks the first byte of a file
//           (restarts the parser), in_tlast marks the final byte
//   out_* : one summary word per file, given when fmt, data and LIST chunks
//           have all been seen or at the last byte, whichever comes first
//   bytes after the summary word are dropped until the next first byte
// throughput: one byte per cycle while in_tready is high; the whole per-byte
//   update is a single registered pass through the chunk walker
// out_tvalid rises at the edge that accepts the byte completing the summary
//   if the output register is empty or being read, else via the skid entry
// stall: results sit in a two-entry buffer; in_tready falls only while both
//   entries are full, so bytes keep flowing while one summary waits
// reset: synchronous rst_n clears the parser to expect the RIFF tag and
//   empties the result buffer
`include "assert_macros.svh"

module wav_header_parser_top import wavhp_pkg::*; #(
  parameter int unsigned POS_WIDTH = PosWidthDefault
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [7:0]              in_tdata,  // [7:0] data_byte
  input  logic                    in_tuser,  // [0] first_byte
  input  logic                    in_tlast,  // last_byte
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // [2:0] status, [4:3] sample_format, [20:5] channel_count,
  // [52:21] sample_rate, [84:53] byte_rate, [100:85] block_alignment,
  // [116:101] sample_bits, [148:117] data_offset, [180:149] data_length
  output logic [OutDataWidth-1:0] out_tdata
);

  logic    in_acc;      // byte word taken this cycle
  logic    res_vld;     // parser finishes a summary on this byte
  result_t res;
  result_t out_res;
  logic    prs_done;    // parser waits for the next file

  assign in_acc = in_tvalid && in_tready;

  // chunk walker and field capture
  wavhp_parser #(
    .POS_WIDTH (POS_WIDTH)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .in_byte  (in_tdata),
    .in_first (in_tuser),
    .in_last  (in_tlast),
    .res_vld  (res_vld),
    .res      (res),
    .prs_done (prs_done)
  );

  // output register with skid entry
  wavhp_out_buf u_out_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .res_vld (res_vld),
    .res     (res),
    .res_rdy (in_tready),
    .out_vld (out_tvalid),
    .out_rdy (out_tready),
    .out_res (out_res)
  );

  // pack fields, first one lowest, zero fill up to whole bytes
  assign out_tdata = {3'b000,
                      out_res.data_length,
                      out_res.data_offset,
                      out_res.sample_bits,
                      out_res.block_alignment,
                      out_res.byte_rate,
                      out_res.sample_rate,
                      out_res.channel_count,
                      out_res.sample_format,
                      out_res.status};

  // skid entry only fills behind a held output word
  `ASSERT_PROP(a_skid_behind_main, clk, rst_n, in_tready || out_tvalid)
  // a finished summary always parks the parser until the next file
  `ASSERT_PROP(a_done_after_result, clk, rst_n, res_vld |=> prs_done)
  // a failing status never carries a sample format
  `ASSERT_NEVER(a_fmt_on_fail, clk, rst_n,
    out_tvalid && (out_res.status != ST_OK) && (out_res.sample_format != 2'd0))

endmodule
